### design/ipc_pkg.sv
`timescale 1ns / 1ps

package ipc_pkg;

    // Default size of the register byte space
    localparam int REG_SPACE_DEF = 64;

    // Item kinds
    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_TIMER = 3'd2;
    localparam logic [2:0] KIND_ACIA  = 3'd3;
    localparam logic [2:0] KIND_ACK   = 3'd4;

    // Control register offsets
    localparam logic [7:0] OFS_GPIP = 8'h01;
    localparam logic [7:0] OFS_IERA = 8'h07;
    localparam logic [7:0] OFS_IERB = 8'h09;
    localparam logic [7:0] OFS_IPRA = 8'h0B;
    localparam logic [7:0] OFS_IPRB = 8'h0D;
    localparam logic [7:0] OFS_ISRA = 8'h0F;
    localparam logic [7:0] OFS_ISRB = 8'h11;
    localparam logic [7:0] OFS_IMRA = 8'h13;
    localparam logic [7:0] OFS_IMRB = 8'h15;
    localparam logic [7:0] OFS_VR   = 8'h17;

    // Reset values of the control registers that are not zero
    localparam logic [7:0] GPIP_RST = 8'h10;
    localparam logic [7:0] VR_RST   = 8'h40;

    // Bit positions
    localparam int GPIP_ACIA_BIT = 4;
    localparam int TIMER_C_BIT   = 5;
    localparam int ACIA_BIT      = 6;
    localparam int VR_SEI_BIT    = 3;

    // Input item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] reg_offset;
        logic [7:0] write_data;
        logic       acia_irq;
    } ipc_req_t;

    // Result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pending;
        logic       vector_valid;
        logic [7:0] vector_number;
    } ipc_rsp_t;

    // Control bank outputs for the item in flight
    typedef struct packed {
        logic       hit;
        logic [7:0] rd_byte;
        logic       irq_pending;
        logic       vector_valid;
        logic [7:0] vector_number;
    } ipc_ctrl_res_t;

    // Offset belongs to the control register bank
    function automatic logic is_ctrl_ofs(input logic [7:0] ofs);
        return (ofs == OFS_GPIP) || (ofs == OFS_IERA) || (ofs == OFS_IERB) ||
               (ofs == OFS_IPRA) || (ofs == OFS_IPRB) || (ofs == OFS_ISRA) ||
               (ofs == OFS_ISRB) || (ofs == OFS_IMRA) || (ofs == OFS_IMRB) ||
               (ofs == OFS_VR);
    endfunction

    // Highest set bit of a byte: {found, index}
    function automatic logic [3:0] prio8(input logic [7:0] v);
        logic [3:0] r;
        r = 4'b0000;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                r = {1'b1, 3'(i)};
            end
        end
        return r;
    endfunction

endpackage

### design/ipc_ram.sv
`timescale 1ns / 1ps

module ipc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/ipc_ctrl_regs.sv
`timescale 1ns / 1ps

module ipc_ctrl_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  ipc_pkg::ipc_req_t     item,
    output ipc_pkg::ipc_ctrl_res_t res
);
    import ipc_pkg::*;

    logic [7:0] gpip_reg, iera_reg, ierb_reg, ipra_reg, iprb_reg;
    logic [7:0] isra_reg, isrb_reg, imra_reg, imrb_reg, vr_reg;
    logic [7:0] gpip_next, iera_next, ierb_next, ipra_next, iprb_next;
    logic [7:0] isra_next, isrb_next, imra_next, imrb_next, vr_next;

    logic [3:0] sel_a, sel_b;
    logic       sei;
    logic [7:0] ready_a_next, ready_b_next;
    logic [7:0] rd_byte;

    assign sei   = vr_reg[VR_SEI_BIT];
    assign sel_a = prio8(ipra_reg & iera_reg & imra_reg);
    assign sel_b = prio8(iprb_reg & ierb_reg & imrb_reg);

    // Next state of the control bank
    always_comb
    begin
        gpip_next = gpip_reg;
        iera_next = iera_reg;
        ierb_next = ierb_reg;
        ipra_next = ipra_reg;
        iprb_next = iprb_reg;
        isra_next = isra_reg;
        isrb_next = isrb_reg;
        imra_next = imra_reg;
        imrb_next = imrb_reg;
        vr_next   = vr_reg;
        case (item.kind)
            KIND_WRITE:
            begin
                case (item.reg_offset)
                    OFS_GPIP: gpip_next = item.write_data;
                    OFS_IERA: iera_next = item.write_data;
                    OFS_IERB: ierb_next = item.write_data;
                    OFS_IPRA: ipra_next = ipra_reg & item.write_data;
                    OFS_IPRB: iprb_next = iprb_reg & item.write_data;
                    OFS_ISRA: isra_next = isra_reg & item.write_data;
                    OFS_ISRB: isrb_next = isrb_reg & item.write_data;
                    OFS_IMRA: imra_next = item.write_data;
                    OFS_IMRB: imrb_next = item.write_data;
                    OFS_VR:   vr_next   = item.write_data;
                    default:  ;
                endcase
            end
            KIND_TIMER:
            begin
                if (ierb_reg[TIMER_C_BIT])
                begin
                    iprb_next[TIMER_C_BIT] = 1'b1;
                end
            end
            KIND_ACIA:
            begin
                // GPIP line is active low
                if (item.acia_irq)
                begin
                    gpip_next[GPIP_ACIA_BIT] = 1'b0;
                    if (!isrb_reg[ACIA_BIT] && ierb_reg[ACIA_BIT])
                    begin
                        iprb_next[ACIA_BIT] = 1'b1;
                    end
                end
                else
                begin
                    gpip_next[GPIP_ACIA_BIT] = 1'b1;
                    iprb_next[ACIA_BIT]      = 1'b0;
                end
            end
            KIND_ACK:
            begin
                // Bank A wins over bank B
                if (sel_a[3])
                begin
                    ipra_next[sel_a[2:0]] = 1'b0;
                    if (sei)
                    begin
                        isra_next[sel_a[2:0]] = 1'b1;
                    end
                end
                else if (sel_b[3])
                begin
                    iprb_next[sel_b[2:0]] = 1'b0;
                    if (sei)
                    begin
                        isrb_next[sel_b[2:0]] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Read mux over the control bank
    always_comb
    begin
        case (item.reg_offset)
            OFS_GPIP: rd_byte = {gpip_reg[7:5], ~item.acia_irq, gpip_reg[3:0]};
            OFS_IERA: rd_byte = iera_reg;
            OFS_IERB: rd_byte = ierb_reg;
            OFS_IPRA: rd_byte = ipra_reg;
            OFS_IPRB: rd_byte = iprb_reg;
            OFS_ISRA: rd_byte = isra_reg;
            OFS_ISRB: rd_byte = isrb_reg;
            OFS_IMRA: rd_byte = imra_reg;
            OFS_IMRB: rd_byte = imrb_reg;
            OFS_VR:   rd_byte = vr_reg;
            default:  rd_byte = 8'h00;
        endcase
    end

    assign ready_a_next = ipra_next & iera_next & imra_next;
    assign ready_b_next = iprb_next & ierb_next & imrb_next;

    // Results for the item in flight
    always_comb
    begin
        res.hit          = is_ctrl_ofs(item.reg_offset);
        res.rd_byte      = rd_byte;
        res.irq_pending  = |(ready_a_next | ready_b_next);
        res.vector_valid = (item.kind == KIND_ACK) && (sel_a[3] || sel_b[3]);
        if (!res.vector_valid)
        begin
            res.vector_number = 8'h00;
        end
        else if (sel_a[3])
        begin
            res.vector_number = {vr_reg[7:4], 1'b1, sel_a[2:0]};
        end
        else
        begin
            res.vector_number = {vr_reg[7:4], 1'b0, sel_b[2:0]};
        end
    end

    // Control bank registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpip_reg <= GPIP_RST;
            iera_reg <= 8'h00;
            ierb_reg <= 8'h00;
            ipra_reg <= 8'h00;
            iprb_reg <= 8'h00;
            isra_reg <= 8'h00;
            isrb_reg <= 8'h00;
            imra_reg <= 8'h00;
            imrb_reg <= 8'h00;
            vr_reg   <= VR_RST;
        end
        else if (en)
        begin
            gpip_reg <= gpip_next;
            iera_reg <= iera_next;
            ierb_reg <= ierb_next;
            ipra_reg <= ipra_next;
            iprb_reg <= iprb_next;
            isra_reg <= isra_next;
            isrb_reg <= isrb_next;
            imra_reg <= imra_next;
            imrb_reg <= imrb_next;
            vr_reg   <= vr_next;
        end
    end

endmodule

### design/interrupt_priority_controller_unit.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-----------------------
// req       | in        | req_valid/req_stall  | ipc_req_t (access/event)
// rsp       | out       | rsp_valid/rsp_stall  | ipc_rsp_t (one per req)
//
// One transfer per cycle while req_stall is low; a result passes the request
// register (with RAM read), then the result register.
// Plain register bytes live in a RAM written and read at request time;
// the control registers are flops updated as the item leaves stage one.
// Reset clears the per-byte valid bits at once: no clearing pass.
// A stalled result holds stage one, and req_stall rises only while both
// stages are full.

module interrupt_priority_controller_unit #(
    parameter int REG_SPACE = ipc_pkg::REG_SPACE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ipc_pkg::ipc_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ipc_pkg::ipc_rsp_t rsp
);
    import ipc_pkg::*;

    localparam int AW = $clog2(REG_SPACE);

    logic                 req_xfer;
    logic                 s1_adv;
    logic                 req_in_range;
    logic [AW-1:0]        req_addr;
    logic                 ram_wr_en;
    logic [7:0]           ram_rd_data;

    logic                 s1_valid_reg;
    ipc_req_t             s1_item_reg;
    logic                 s1_vld_reg;
    logic                 s1_in_range;
    logic [REG_SPACE-1:0] byte_vld_reg;

    ipc_ctrl_res_t        ctrl_res;
    ipc_rsp_t             rsp_next;
    ipc_rsp_t             rsp_reg;
    logic                 rsp_valid_reg;

    // Flow control
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_adv;
    assign req_xfer  = req_valid && !req_stall;

    // Plain byte store: written and read on the request transfer
    assign req_in_range = ({1'b0, req.reg_offset} < 9'(REG_SPACE));
    assign req_addr     = req.reg_offset[AW-1:0];
    assign ram_wr_en    = req_xfer && (req.kind == KIND_WRITE) && req_in_range &&
                          !is_ctrl_ofs(req.reg_offset);

    ipc_ram #(
        .WIDTH (8),
        .DEPTH (REG_SPACE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (req_addr),
        .wr_data (req.write_data),
        .rd_en   (req_xfer),
        .rd_addr (req_addr),
        .rd_data (ram_rd_data)
    );

    // Per-byte valid bits: unwritten bytes read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= '0;
        end
        else if (ram_wr_en)
        begin
            byte_vld_reg[req_addr] <= 1'b1;
        end
    end

    // Stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage one payload
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_item_reg <= req;
            s1_vld_reg  <= req_in_range && byte_vld_reg[req_addr];
        end
    end

    assign s1_in_range = ({1'b0, s1_item_reg.reg_offset} < 9'(REG_SPACE));

    ipc_ctrl_regs u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s1_adv),
        .item  (s1_item_reg),
        .res   (ctrl_res)
    );

    // Result assembly
    always_comb
    begin
        rsp_next.read_data = 8'h00;
        if (s1_item_reg.kind == KIND_READ && s1_in_range)
        begin
            if (ctrl_res.hit)
            begin
                rsp_next.read_data = ctrl_res.rd_byte;
            end
            else if (s1_vld_reg)
            begin
                rsp_next.read_data = ram_rd_data;
            end
        end
        rsp_next.irq_pending   = ctrl_res.irq_pending;
        rsp_next.vector_valid  = ctrl_res.vector_valid;
        rsp_next.vector_number = ctrl_res.vector_number;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ipc_pkg::*;

    localparam int REG_SPACE = REG_SPACE_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TOTAL_ITEMS = 1350;
    localparam int QUIET_TAIL = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    // Kinds past acknowledge do nothing
    localparam logic [2:0] KIND_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] KIND_LAST_UNUSED  = 3'd7;

    localparam logic [7:0] VR_BASE_MASK = 8'hF0;
    localparam logic [7:0] BANK_A_BASE  = 8'h08;

    localparam logic [7:0] CTRL_OFS [10] = '{OFS_GPIP, OFS_IERA, OFS_IERB, OFS_IPRA,
        OFS_IPRB, OFS_ISRA, OFS_ISRB, OFS_IMRA, OFS_IMRB, OFS_VR};

    // Mirrors the register file and holds results still due from the block
    class irq_scoreboard;
        bit [7:0] regs [REG_SPACE];
        ipc_rsp_t due_responses [$];
        int errors;

        function new();
            foreach (regs[i])
                regs[i] = 8'h00;
            regs[OFS_VR] = VR_RST;
            regs[OFS_GPIP] = GPIP_RST;
            errors = 0;
        endfunction

        // Pending and in-service bytes can only be cleared by a write
        function bit is_clear_only(logic [7:0] ofs);
            return (ofs == OFS_IPRA) || (ofs == OFS_IPRB) ||
                   (ofs == OFS_ISRA) || (ofs == OFS_ISRB);
        endfunction

        // Serve the top ready channel of one bank; -1 when none
        function int take_highest(logic [7:0] ipr, logic [7:0] ier, logic [7:0] imr,
                                  logic [7:0] isr, bit sei);
            bit [7:0] ready;
            ready = regs[ipr] & regs[ier] & regs[imr];
            for (int b = 7; b >= 0; b--) begin
                if (ready[b]) begin
                    if (sei)
                        regs[isr][b] = 1'b1;
                    regs[ipr][b] = 1'b0;
                    return b;
                end
            end
            return -1;
        endfunction

        function ipc_rsp_t predict_response(ipc_req_t t);
            ipc_rsp_t r;
            bit [7:0] v;
            bit [7:0] base;
            bit sei;
            int ch;
            r = '0;
            case (t.kind)
                KIND_WRITE:
                    if (int'(t.reg_offset) < REG_SPACE) begin
                        if (is_clear_only(t.reg_offset))
                            regs[t.reg_offset] &= t.write_data;
                        else
                            regs[t.reg_offset] = t.write_data;
                    end
                KIND_READ:
                    if (int'(t.reg_offset) < REG_SPACE) begin
                        v = regs[t.reg_offset];
                        // GPIP shows the live request level, inverted
                        if (t.reg_offset == OFS_GPIP)
                            v[GPIP_ACIA_BIT] = !t.acia_irq;
                        r.read_data = v;
                    end
                KIND_TIMER:
                    if (regs[OFS_IERB][TIMER_C_BIT])
                        regs[OFS_IPRB][TIMER_C_BIT] = 1'b1;
                KIND_ACIA:
                    if (t.acia_irq) begin
                        regs[OFS_GPIP][GPIP_ACIA_BIT] = 1'b0;
                        if (!regs[OFS_ISRB][ACIA_BIT] && regs[OFS_IERB][ACIA_BIT])
                            regs[OFS_IPRB][ACIA_BIT] = 1'b1;
                    end else begin
                        regs[OFS_IPRB][ACIA_BIT] = 1'b0;
                        regs[OFS_GPIP][GPIP_ACIA_BIT] = 1'b1;
                    end
                KIND_ACK: begin
                    base = regs[OFS_VR] & VR_BASE_MASK;
                    sei = regs[OFS_VR][VR_SEI_BIT];
                    // Bank A wins over bank B
                    ch = take_highest(OFS_IPRA, OFS_IERA, OFS_IMRA, OFS_ISRA, sei);
                    if (ch >= 0) begin
                        r.vector_valid = 1'b1;
                        r.vector_number = base + BANK_A_BASE + 8'(ch);
                    end else begin
                        ch = take_highest(OFS_IPRB, OFS_IERB, OFS_IMRB, OFS_ISRB, sei);
                        if (ch >= 0) begin
                            r.vector_valid = 1'b1;
                            r.vector_number = base + 8'(ch);
                        end
                    end
                end
                default: ;
            endcase
            r.irq_pending = |((regs[OFS_IPRA] & regs[OFS_IERA] & regs[OFS_IMRA]) |
                              (regs[OFS_IPRB] & regs[OFS_IERB] & regs[OFS_IMRB]));
            return r;
        endfunction

        function void note_request(ipc_req_t t);
            due_responses.push_back(predict_response(t));
        endfunction

        function void check_response(ipc_rsp_t got);
            ipc_rsp_t want;
            bit bad;
            if (due_responses.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected response: rd=%02h pend=%0d vv=%0d vec=%02h",
                             got.read_data, got.irq_pending, got.vector_valid,
                             got.vector_number);
                return;
            end
            want = due_responses.pop_front();
            bad = (got.read_data !== want.read_data) ||
                  (got.irq_pending !== want.irq_pending) ||
                  (got.vector_valid !== want.vector_valid) ||
                  (got.vector_number !== want.vector_number);
            if (bad) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"response mismatch: exp rd=%02h pend=%0d vv=%0d vec=%02h,",
                              " got rd=%02h pend=%0d vv=%0d vec=%02h"},
                             want.read_data, want.irq_pending, want.vector_valid,
                             want.vector_number, got.read_data, got.irq_pending,
                             got.vector_valid, got.vector_number);
            end
        endfunction

        function int outstanding();
            return due_responses.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    ipc_req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    ipc_rsp_t rsp;

    irq_scoreboard sb = new();
    int idle_pct = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int items_sent = 0;

    interrupt_priority_controller_unit #(
        .REG_SPACE (REG_SPACE)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 12 ns clock
    always #6 clk = ~clk;

    // Result side stalls in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(99) < idle_pct)
        begin
            stall_left = $urandom_range(7, 1) - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic ipc_req_t make_item(logic [2:0] kind, logic [7:0] ofs,
                                           logic [7:0] data, logic acia);
        ipc_req_t t;
        t.kind = kind;
        t.reg_offset = ofs;
        t.write_data = data;
        t.acia_irq = acia;
        return t;
    endfunction

    function automatic logic [7:0] random_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return 8'hFF;
        if (pick == 1)
            return 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] random_offset();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return CTRL_OFS[$urandom_range(9)];
        if (pick < 90)
            return 8'($urandom_range(REG_SPACE - 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic ipc_req_t random_item();
        int pick;
        logic [2:0] kind;
        pick = $urandom_range(99);
        if (pick < 28)
            kind = KIND_WRITE;
        else if (pick < 52)
            kind = KIND_READ;
        else if (pick < 66)
            kind = KIND_TIMER;
        else if (pick < 80)
            kind = KIND_ACIA;
        else if (pick < 96)
            kind = KIND_ACK;
        else
            kind = 3'($urandom_range(KIND_LAST_UNUSED, KIND_FIRST_UNUSED));
        return make_item(kind, random_offset(), random_byte(), 1'($urandom_range(1)));
    endfunction

    // One request transfer, with an optional gap ahead of it
    task automatic send_item(input ipc_req_t t);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(7, 1);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= t;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Arm a bank B source, fire it, then acknowledge
    task automatic send_interrupt_sequence();
        logic acia;
        acia = 1'($urandom_range(1));
        send_item(make_item(KIND_WRITE, OFS_IERB, random_byte() | 8'h60, acia));
        send_item(make_item(KIND_WRITE, OFS_IMRB, random_byte() | 8'h60, acia));
        if ($urandom_range(1))
            send_item(make_item(KIND_TIMER, random_offset(), random_byte(), acia));
        else
            send_item(make_item(KIND_ACIA, random_offset(), random_byte(), 1'b1));
        send_item(make_item(KIND_ACK, random_offset(), random_byte(), acia));
    endtask

    task automatic run_directed();
        send_item(make_item(KIND_READ, OFS_GPIP, 8'h00, 1'b0));
        send_item(make_item(KIND_READ, OFS_GPIP, 8'hFF, 1'b1));
        send_item(make_item(KIND_READ, OFS_VR, 8'h00, 1'b0));
        // acknowledge with nothing ready
        send_item(make_item(KIND_ACK, 8'h00, 8'h00, 1'b0));
        send_item(make_item(KIND_WRITE, OFS_IERB, 8'hFF, 1'b0));
        send_item(make_item(KIND_WRITE, OFS_IMRB, 8'hFF, 1'b1));
        send_item(make_item(KIND_TIMER, 8'h00, 8'h00, 1'b0));
        send_item(make_item(KIND_ACIA, 8'h00, 8'h00, 1'b1));
        send_item(make_item(KIND_READ, OFS_GPIP, 8'h00, 1'b0));
        // AEI mode: in-service untouched
        send_item(make_item(KIND_ACK, 8'hFF, 8'hFF, 1'b1));
        send_item(make_item(KIND_WRITE, OFS_VR, 8'hF8, 1'b0));
        // SEI mode: served bit goes in-service
        send_item(make_item(KIND_ACK, 8'h00, 8'h00, 1'b0));
        send_item(make_item(KIND_ACIA, 8'h00, 8'h00, 1'b1));
        send_item(make_item(KIND_READ, OFS_ISRB, 8'h00, 1'b0));
        send_item(make_item(KIND_WRITE, OFS_ISRB, 8'h00, 1'b0));
        send_item(make_item(KIND_ACIA, 8'h00, 8'h00, 1'b0));
        send_item(make_item(KIND_WRITE, OFS_IERA, 8'hFF, 1'b0));
        send_item(make_item(KIND_WRITE, OFS_IMRA, 8'hFF, 1'b0));
        send_item(make_item(KIND_WRITE, OFS_IPRA, 8'hFF, 1'b0));
        // top of range and beyond it
        send_item(make_item(KIND_WRITE, 8'(REG_SPACE - 1), 8'hA5, 1'b0));
        send_item(make_item(KIND_READ, 8'(REG_SPACE - 1), 8'h00, 1'b0));
        send_item(make_item(KIND_WRITE, 8'hFF, 8'h5A, 1'b1));
        send_item(make_item(KIND_READ, 8'hFF, 8'h00, 1'b1));
        for (logic [3:0] k = KIND_FIRST_UNUSED; k <= KIND_LAST_UNUSED; k++)
            send_item(make_item(k[2:0], 8'hFF, 8'hFF, 1'b1));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 30;
        run_directed();

        // Random part; gap density changes per stretch, none in the tail
        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= TOTAL_ITEMS - QUIET_TAIL)
                idle_pct = 0;
            else if (items_sent % 100 < 4)
                idle_pct = $urandom_range(2) * 25;
            if ($urandom_range(4) == 0)
                send_interrupt_sequence();
            else
                send_item(random_item());
        end
        req_valid <= 1'b0;

        // Drain, then allow for stray results
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
